// ===== rtl/ssc_pkg.sv =====
// shared types, constants and coefficient table of the state-space controller
package ssc_pkg;

   // controller dimensions and number formats
   localparam int STATE_COUNT = 6;
   localparam int MEAS_COUNT  = 3;
   localparam int DATA_WIDTH  = 24;
   localparam int COEF_WIDTH  = 24;
   localparam int STATE_WIDTH = 32;
   localparam int COEF_FRAC   = 22;

   // coefficient table layout: A, B, C, D
   localparam int ROM_B    = STATE_COUNT * STATE_COUNT;
   localparam int ROM_C    = ROM_B + STATE_COUNT * MEAS_COUNT;
   localparam int ROM_SIZE = ROM_C + STATE_COUNT + MEAS_COUNT;

   // one row is a dot product over the state and the measurements
   localparam int TERM_COUNT = STATE_COUNT + MEAS_COUNT;
   localparam int ROW_W      = $clog2(STATE_COUNT + 1);
   localparam int COL_W      = $clog2(TERM_COUNT);
   localparam int SIDX_W     = $clog2(STATE_COUNT);
   localparam int ROM_AW     = $clog2(ROM_SIZE);
   localparam int MEM_AW     = $clog2(2 * STATE_COUNT);

   // request codes
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_CLEAR  = 1'b1;

   typedef struct packed {
      logic                         req_type;
      logic signed [DATA_WIDTH-1:0] pitch_rate;
      logic signed [DATA_WIDTH-1:0] vertical_accel;
      logic signed [DATA_WIDTH-1:0] extra_accel;
   } req_word_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] control_output;
      logic                         saturated;
   } rsp_word_type;

   // one product term on its way through the multiply-accumulate
   typedef struct packed {
      logic              valid;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic              first;
      logic              last;
      logic [ROM_AW-1:0] coef_idx;
   } term_tag_type;

   // enable and entry of one state memory port
   typedef struct packed {
      logic              en;
      logic [SIDX_W-1:0] idx;
   } mem_port_type;

   // signed Q1.22 controller coefficients
   function automatic logic signed [COEF_WIDTH-1:0] coef_rom(input logic [ROM_AW-1:0] idx);
      int v;
      case (int'(idx))
         // A
         0:  v = -1036403;
         1:  v = 1749136;
         2:  v = 1554822;
         3:  v = 1571829;
         4:  v = 409314;
         5:  v = -495513;
         6:  v = 2041488;
         7:  v = 2080085;
         8:  v = -699127;
         9:  v = -1038108;
         10: v = 248255;
         11: v = -300536;
         12: v = -3199303;
         13: v = -22373;
         14: v = 3552863;
         15: v = 2052618;
         16: v = 189693;
         17: v = -229641;
         18: v = -1330191;
         19: v = -630469;
         20: v = -1574238;
         21: v = 4444233;
         22: v = 607613;
         23: v = -735572;
         24: v = -962557;
         25: v = -2227607;
         26: v = 87511;
         27: v = 197619;
         28: v = -741548;
         29: v = 172272;
         30: v = -163957;
         31: v = -379440;
         32: v = 14906;
         33: v = 33662;
         34: v = 587088;
         35: v = 3482847;
         // B
         36: v = 81360;
         37: v = 2888;
         38: v = 118;
         39: v = -62104;
         40: v = 2112;
         41: v = -3578;
         42: v = 51711;
         43: v = 971;
         44: v = 227;
         45: v = 17664;
         46: v = 3824;
         47: v = -4008;
         48: v = 12986;
         49: v = -961;
         50: v = 1168;
         51: v = 2212;
         52: v = -164;
         53: v = 199;
         // C
         54: v = -1410965;
         55: v = -3265341;
         56: v = 128279;
         57: v = 289681;
         58: v = 5052301;
         59: v = -6116286;
         // D
         60: v = 19036;
         61: v = -1409;
         62: v = 1712;
         default: v = 0;
      endcase
      return COEF_WIDTH'(v);
   endfunction

endpackage

// ===== rtl/ssc_seq.sv =====
// term sequencer: walks the output row and the state rows one term per cycle
module ssc_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  done,
   output ssc_pkg::term_tag_type tag,
   output ssc_pkg::mem_port_type rd,
   output logic                  busy
);

   logic                          run_ff, run_in;
   logic                          busy_ff, busy_in;
   logic [ssc_pkg::ROW_W-1:0]     row_ff, row_in;
   logic [ssc_pkg::COL_W-1:0]     col_ff, col_in;
   logic [ssc_pkg::ROM_AW-1:0]    a_base_ff, a_base_in;
   logic [ssc_pkg::ROM_AW-1:0]    b_base_ff, b_base_in;
   logic                          col_is_state;
   logic                          col_last;

   assign col_is_state = col_ff < ssc_pkg::COL_W'(ssc_pkg::STATE_COUNT);
   assign col_last     = col_ff == ssc_pkg::COL_W'(ssc_pkg::TERM_COUNT - 1);

   // counters: row 0 is the output, rows 1.. are the new state elements
   always_comb begin
      run_in    = run_ff;
      busy_in   = busy_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      a_base_in = a_base_ff;
      b_base_in = b_base_ff;
      if (start) begin
         run_in    = 1'b1;
         busy_in   = 1'b1;
         row_in    = '0;
         col_in    = '0;
         a_base_in = '0;
         b_base_in = ssc_pkg::ROM_AW'(ssc_pkg::ROM_B - ssc_pkg::STATE_COUNT);
      end else if (run_ff) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
            if (row_ff != '0) begin
               a_base_in = a_base_ff + ssc_pkg::ROM_AW'(ssc_pkg::STATE_COUNT);
               b_base_in = b_base_ff + ssc_pkg::ROM_AW'(ssc_pkg::MEAS_COUNT);
            end
            if (row_ff == ssc_pkg::ROW_W'(ssc_pkg::STATE_COUNT)) begin
               run_in = 1'b0;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
      if (done) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         busy_ff   <= 1'b0;
         row_ff    <= '0;
         col_ff    <= '0;
         a_base_ff <= '0;
         b_base_ff <= '0;
      end else begin
         run_ff    <= run_in;
         busy_ff   <= busy_in;
         row_ff    <= row_in;
         col_ff    <= col_in;
         a_base_ff <= a_base_in;
         b_base_ff <= b_base_in;
      end
   end

   // issued term: coefficient index and state read
   always_comb begin
      tag.valid = run_ff;
      tag.row   = row_ff;
      tag.col   = col_ff;
      tag.first = col_ff == '0;
      tag.last  = col_last;
      if (row_ff == '0) begin
         tag.coef_idx = ssc_pkg::ROM_AW'(ssc_pkg::ROM_C) + ssc_pkg::ROM_AW'(col_ff);
      end else if (col_is_state) begin
         tag.coef_idx = a_base_ff + ssc_pkg::ROM_AW'(col_ff);
      end else begin
         tag.coef_idx = b_base_ff + ssc_pkg::ROM_AW'(col_ff);
      end
      rd.en  = run_ff && col_is_state;
      rd.idx = ssc_pkg::SIDX_W'(col_ff);
   end

   assign busy = busy_ff;

   // issuing only happens inside a busy step
   a_run_busy: assert property (@(posedge clock) disable iff (reset) run_ff |-> busy_ff)
      else $error("term issued outside a busy step");

   // a new sample never starts over a running one
   a_start_idle: assert property (@(posedge clock) disable iff (reset) start |-> !busy_ff)
      else $error("sample started while busy");

endmodule

// ===== rtl/ssc_state_mem.sv =====
// ping-pong state memory: read the current bank, write the next one
module ssc_state_mem #(
   parameter int STATE_WIDTH = ssc_pkg::STATE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  ssc_pkg::mem_port_type         rd,
   input  ssc_pkg::mem_port_type         wr,
   input  logic signed [STATE_WIDTH-1:0] wr_data,
   input  logic                          swap,
   input  logic                          clear,
   output logic signed [STATE_WIDTH-1:0] rd_data
);

   logic signed [STATE_WIDTH-1:0] mem [2*ssc_pkg::STATE_COUNT];
   logic signed [STATE_WIDTH-1:0] rd_data_ff;
   logic                          bank_ff, bank_in;
   logic                          zero_ff, zero_in;
   logic [ssc_pkg::MEM_AW-1:0]    rd_addr;
   logic [ssc_pkg::MEM_AW-1:0]    wr_addr;

   // bank base plus element index
   assign rd_addr = (bank_ff ? ssc_pkg::MEM_AW'(ssc_pkg::STATE_COUNT) : '0)
                    + ssc_pkg::MEM_AW'(rd.idx);
   assign wr_addr = (bank_ff ? '0 : ssc_pkg::MEM_AW'(ssc_pkg::STATE_COUNT))
                    + ssc_pkg::MEM_AW'(wr.idx);

   // storage with registered read; a cleared bank reads as zero
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd.en) begin
         rd_data_ff <= zero_ff ? '0 : mem[rd_addr];
      end
   end

   // bank select and zero mark
   always_comb begin
      bank_in = swap ? !bank_ff : bank_ff;
      zero_in = zero_ff;
      if (clear) begin
         zero_in = 1'b1;
      end else if (swap) begin
         zero_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff <= 1'b0;
         zero_ff <= 1'b1;
      end else begin
         bank_ff <= bank_in;
         zero_ff <= zero_in;
      end
   end

   assign rd_data = rd_data_ff;

   // a clear request only arrives while no update is being written
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset) clear |-> !wr.en)
      else $error("clear during state write-back");

   // the bank flips together with the last state write
   a_swap_write: assert property (@(posedge clock) disable iff (reset) swap |-> wr.en)
      else $error("bank swap without final write");

endmodule

// ===== rtl/ssc_mac.sv =====
// shared multiply-accumulate with rounding, saturation and result capture
module ssc_mac #(
   parameter int STATE_WIDTH = ssc_pkg::STATE_WIDTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  ssc_pkg::req_word_type         req,
   input  ssc_pkg::term_tag_type         tag,
   input  logic signed [STATE_WIDTH-1:0] rd_data,
   output ssc_pkg::mem_port_type         wr,
   output logic signed [STATE_WIDTH-1:0] wr_data,
   output logic                          done,
   output ssc_pkg::rsp_word_type         rsp
);

   localparam int PROD_W = ssc_pkg::COEF_WIDTH + STATE_WIDTH;
   localparam int ACC_W  = PROD_W - ssc_pkg::COEF_FRAC + 5;
   localparam logic signed [ACC_W-1:0] U_MAX = ACC_W'({(ssc_pkg::DATA_WIDTH-1){1'b1}});
   localparam logic signed [ACC_W-1:0] U_MIN = ~U_MAX;
   localparam logic signed [ACC_W-1:0] X_MAX = ACC_W'({(STATE_WIDTH-1){1'b1}});
   localparam logic signed [ACC_W-1:0] X_MIN = ~X_MAX;

   logic signed [ssc_pkg::DATA_WIDTH-1:0] meas_ff [ssc_pkg::MEAS_COUNT];
   ssc_pkg::term_tag_type                 tag1_ff, tag2_ff, tag3_ff;
   logic signed [ssc_pkg::COEF_WIDTH-1:0] coef1_ff;
   logic signed [STATE_WIDTH-1:0]         operand;
   logic signed [PROD_W-1:0]              prod_in, prod_ff;
   logic [ACC_W-1:0]                      round_bit;
   logic signed [ACC_W-1:0]               acc_in, acc_ff;
   logic signed [ssc_pkg::DATA_WIDTH-1:0] u_clip, u_ff;
   logic signed [STATE_WIDTH-1:0]         x_clip;
   logic                                  u_hit, x_hit;
   logic                                  sat_ff;
   logic                                  row_end;

   // measurements held for the whole step
   always_ff @(posedge clock) begin
      if (load) begin
         meas_ff[0] <= req.pitch_rate;
         meas_ff[1] <= req.vertical_accel;
         meas_ff[2] <= req.extra_accel;
      end
   end

   // coefficient lookup alongside the state read
   always_ff @(posedge clock) begin
      coef1_ff <= ssc_pkg::coef_rom(tag.coef_idx);
   end

   // operand: state word or a measurement
   always_comb begin
      operand = rd_data;
      for (int j = 0; j < ssc_pkg::MEAS_COUNT; j++) begin
         if (tag1_ff.col == ssc_pkg::COL_W'(ssc_pkg::STATE_COUNT + j)) begin
            operand = STATE_WIDTH'(meas_ff[j]);
         end
      end
      prod_in = coef1_ff * operand;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   // round to nearest, ties up, then accumulate the row
   always_comb begin
      round_bit = ACC_W'(prod_ff[ssc_pkg::COEF_FRAC-1]);
      acc_in    = (tag2_ff.first ? '0 : acc_ff) + ACC_W'(prod_ff >>> ssc_pkg::COEF_FRAC)
                  + round_bit;
   end

   always_ff @(posedge clock) begin
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // pipeline tags
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag1_ff <= tag;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   // saturation of the finished row sum
   always_comb begin
      row_end = tag3_ff.valid && tag3_ff.last;
      u_hit   = (acc_ff > U_MAX) || (acc_ff < U_MIN);
      x_hit   = (acc_ff > X_MAX) || (acc_ff < X_MIN);
      if (acc_ff > U_MAX) begin
         u_clip = U_MAX[ssc_pkg::DATA_WIDTH-1:0];
      end else if (acc_ff < U_MIN) begin
         u_clip = U_MIN[ssc_pkg::DATA_WIDTH-1:0];
      end else begin
         u_clip = acc_ff[ssc_pkg::DATA_WIDTH-1:0];
      end
      if (acc_ff > X_MAX) begin
         x_clip = X_MAX[STATE_WIDTH-1:0];
      end else if (acc_ff < X_MIN) begin
         x_clip = X_MIN[STATE_WIDTH-1:0];
      end else begin
         x_clip = acc_ff[STATE_WIDTH-1:0];
      end
   end

   // output row is kept, state rows are written back
   always_ff @(posedge clock) begin
      if (row_end) begin
         if (tag3_ff.row == '0) begin
            u_ff   <= u_clip;
            sat_ff <= u_hit;
         end else begin
            sat_ff <= sat_ff | x_hit;
         end
      end
   end

   always_comb begin
      wr.en   = row_end && (tag3_ff.row != '0);
      wr.idx  = ssc_pkg::SIDX_W'(tag3_ff.row - 1'b1);
      wr_data = x_clip;
      done    = row_end && (tag3_ff.row == ssc_pkg::ROW_W'(ssc_pkg::STATE_COUNT));
      rsp.control_output = u_ff;
      rsp.saturated      = sat_ff | x_hit;
   end

   // a continuing term always has its predecessor one stage ahead
   a_acc_chain: assert property (@(posedge clock) disable iff (reset)
      (tag2_ff.valid && !tag2_ff.first) |-> tag3_ff.valid)
      else $error("accumulation chain broken");

   // the step ends on the last state row
   a_done_write: assert property (@(posedge clock) disable iff (reset) done |-> wr.en)
      else $error("step done without final state write");

endmodule

// ===== rtl/state_space_controller_step.sv =====
// top level of the fixed-point state-space controller
//
//   channel  direction  handshake              word
//   req      in         req_valid / req_stall  ssc_pkg::req_word_type
//   rsp      out        rsp_valid / rsp_stall  ssc_pkg::rsp_word_type
//
// a sample word runs 63 product terms through one shared multiply-accumulate,
// one coefficient per cycle, then through the read, product and accumulator
// registers and the holding and output registers; with the result side free
// the next word is taken once the result has left the holding register.
// a clear word is taken without starting a step and gives no result.
// reset is synchronous and active high; the state reads as zero after it.
// requests stall while a step runs or the holding register is full; the holding
// register moves into the output register once that is free, so a result held
// there by rsp_stall does not keep the next word out.
module state_space_controller_step #(
   parameter int STATE_WIDTH = ssc_pkg::STATE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  ssc_pkg::req_word_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ssc_pkg::rsp_word_type rsp_data
);

   logic                          accept;
   logic                          start;
   logic                          clear;
   logic                          busy;
   logic                          done;
   ssc_pkg::term_tag_type         tag;
   ssc_pkg::mem_port_type         rd;
   ssc_pkg::mem_port_type         wr;
   logic signed [STATE_WIDTH-1:0] rd_data;
   logic signed [STATE_WIDTH-1:0] wr_data;
   ssc_pkg::rsp_word_type         mac_rsp;
   logic                          pend_ff, pend_in;
   ssc_pkg::rsp_word_type         pend_word_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   ssc_pkg::rsp_word_type         rsp_word_ff;
   logic                          rsp_free;

   // request decode
   assign req_stall = busy || pend_ff;
   assign accept    = req_valid && !req_stall;
   assign start     = accept && (req_data.req_type == ssc_pkg::REQ_SAMPLE);
   assign clear     = accept && (req_data.req_type == ssc_pkg::REQ_CLEAR);

   ssc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .start (start),
      .done  (done),
      .tag   (tag),
      .rd    (rd),
      .busy  (busy)
   );

   ssc_state_mem #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd      (rd),
      .wr      (wr),
      .wr_data (wr_data),
      .swap    (done),
      .clear   (clear),
      .rd_data (rd_data)
   );

   ssc_mac #(
      .STATE_WIDTH (STATE_WIDTH)
   ) u_mac (
      .clock   (clock),
      .reset   (reset),
      .load    (start),
      .req     (req_data),
      .tag     (tag),
      .rd_data (rd_data),
      .wr      (wr),
      .wr_data (wr_data),
      .done    (done),
      .rsp     (mac_rsp)
   );

   // holding register and output register
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         pend_in = 1'b1;
      end else if (pend_ff && rsp_free) begin
         pend_in = 1'b0;
      end
      if (pend_ff && rsp_free) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         pend_word_ff <= mac_rsp;
      end
      if (pend_ff && rsp_free) begin
         rsp_word_ff <= pend_word_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   // a held result and a running step never coexist
   a_pend_idle: assert property (@(posedge clock) disable iff (reset) !(pend_ff && busy))
      else $error("result held during a running step");

   // a finishing step always finds the holding register empty
   a_done_room: assert property (@(posedge clock) disable iff (reset) done |-> !pend_ff)
      else $error("result overwritten in holding register");

endmodule

// ===== sim/tb_state_space_controller_step.sv =====
// self-checking testbench for the fixed-point state-space controller
`timescale 1ns / 1ps

module tb_state_space_controller_step;
   import ssc_pkg::*;

   localparam int DIRECTED_ROWS = 25;
   localparam int RANDOM_WORDS  = 1525;
   localparam int DRAIN_EVERY   = 250;
   localparam int CYCLE_LIMIT   = 800_000;
   localparam int QUIET_FROM    = 30_000;
   localparam int QUIET_TO      = 50_000;
   localparam int TAIL_CYCLES   = 100;
   localparam int PRINT_CAP     = 20;

   localparam logic signed [DATA_WIDTH-1:0] MEAS_MAX  = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] MEAS_MIN  = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic signed [DATA_WIDTH-1:0] MEAS_ZERO = '0;
   localparam logic signed [DATA_WIDTH-1:0] MEAS_NEG1 = '1;
   localparam logic signed [DATA_WIDTH-1:0] MEAS_LSB  = 1;

   typedef enum int {MEAS_HIGH, MEAS_LOW, MEAS_ANY, MEAS_NEAR_ZERO, MEAS_NONE} meas_kind_e;

   // one directed row; the result is typed in only where it is obvious
   typedef struct {
      logic                         op;
      logic signed [DATA_WIDTH-1:0] y0;
      logic signed [DATA_WIDTH-1:0] y1;
      logic signed [DATA_WIDTH-1:0] y2;
      bit                           typed;
      logic signed [DATA_WIDTH-1:0] u;
      logic                         sat;
   } directed_row_t;

   // one request word with its typed result and a drain marker
   typedef struct {
      req_word_type word;
      bit           typed;
      rsp_word_type want;
      bit           drain;
   } stim_entry_t;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_data;

   // signed Q1.22 gains: A row-major, B row-major, C, D
   int ctl_gain [ROM_SIZE] = '{
      -1036403, 1749136, 1554822, 1571829, 409314, -495513,
      2041488, 2080085, -699127, -1038108, 248255, -300536,
      -3199303, -22373, 3552863, 2052618, 189693, -229641,
      -1330191, -630469, -1574238, 4444233, 607613, -735572,
      -962557, -2227607, 87511, 197619, -741548, 172272,
      -163957, -379440, 14906, 33662, 587088, 3482847,
      81360, 2888, 118,
      -62104, 2112, -3578,
      51711, 971, 227,
      17664, 3824, -4008,
      12986, -961, 1168,
      2212, -164, 199,
      -1410965, -3265341, 128279, 289681, 5052301, -6116286,
      19036, -1409, 1712
   };

   directed_row_t directed_rows [DIRECTED_ROWS] = '{
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_ZERO, MEAS_ZERO, 1'b1, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_ZERO, MEAS_ZERO, 1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MIN,  MEAS_ZERO, MEAS_ZERO, 1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_MAX,  MEAS_ZERO, 1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_MIN,  MEAS_ZERO, 1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_ZERO, MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_ZERO, MEAS_MIN,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MIN,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_NEG1, MEAS_NEG1, MEAS_NEG1, 1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_LSB,  MEAS_LSB,  MEAS_LSB,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_CLEAR,  MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_ZERO, MEAS_ZERO, 1'b1, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MAX,  MEAS_MAX,  MEAS_MAX,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MIN,  MEAS_MIN,  MEAS_MIN,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_CLEAR,  MEAS_ZERO, MEAS_ZERO, MEAS_ZERO, 1'b0, MEAS_ZERO, 1'b0},
      '{REQ_CLEAR,  MEAS_NEG1, MEAS_MIN,  MEAS_LSB,  1'b0, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_ZERO, MEAS_ZERO, MEAS_ZERO, 1'b1, MEAS_ZERO, 1'b0},
      '{REQ_SAMPLE, MEAS_MIN,  MEAS_MAX,  MEAS_MIN,  1'b0, MEAS_ZERO, 1'b0}
   };

   // controller state as the predictor sees it, Q16.16
   longint       ctl_state [STATE_COUNT];
   stim_entry_t  stim_q [$];
   rsp_word_type expected_outputs [$];
   stim_entry_t  driven_word;

   int cycle_count     = 0;
   int mismatch_count  = 0;
   int words_total     = 0;
   int words_accepted  = 0;
   int samples_sent    = 0;
   int clears_sent     = 0;
   int results_checked = 0;
   int clipped_results = 0;

   state_space_controller_step u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP) begin
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                  want);
      end
   endtask

   // gain (Q.22) times value (Q.16), rounded half up back to Q.16
   function automatic longint round_product(input longint gain, input longint value);
      return (gain * value + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC;
   endfunction

   function automatic longint clamp_to(input longint value, input int width, inout bit clipped);
      longint top;
      top = (longint'(1) <<< (width - 1)) - 1;
      if (value > top) begin
         clipped = 1'b1;
         return top;
      end
      if (value < -top - 1) begin
         clipped = 1'b1;
         return -top - 1;
      end
      return value;
   endfunction

   // one controller step: output from the old state, then the state update
   task automatic predict_word(input stim_entry_t item);
      longint       meas [MEAS_COUNT];
      longint       next_state [STATE_COUNT];
      longint       acc;
      bit           clipped;
      rsp_word_type want;
      if (item.word.req_type == REQ_CLEAR) begin
         foreach (ctl_state[i]) ctl_state[i] = 0;
         clears_sent++;
         return;
      end
      meas[0] = longint'(item.word.pitch_rate);
      meas[1] = longint'(item.word.vertical_accel);
      meas[2] = longint'(item.word.extra_accel);
      clipped = 1'b0;
      acc = 0;
      for (int i = 0; i < STATE_COUNT; i++)
         acc += round_product(ctl_gain[ROM_C + i], ctl_state[i]);
      for (int j = 0; j < MEAS_COUNT; j++)
         acc += round_product(ctl_gain[ROM_C + STATE_COUNT + j], meas[j]);
      acc = clamp_to(acc, DATA_WIDTH, clipped);
      for (int i = 0; i < STATE_COUNT; i++) begin
         next_state[i] = 0;
         for (int j = 0; j < STATE_COUNT; j++)
            next_state[i] += round_product(ctl_gain[i * STATE_COUNT + j], ctl_state[j]);
         for (int j = 0; j < MEAS_COUNT; j++)
            next_state[i] += round_product(ctl_gain[ROM_B + i * MEAS_COUNT + j], meas[j]);
         next_state[i] = clamp_to(next_state[i], ssc_pkg::STATE_WIDTH, clipped);
      end
      ctl_state = next_state;
      want.control_output = acc[DATA_WIDTH-1:0];
      want.saturated      = clipped;
      expected_outputs.push_back(item.typed ? item.want : want);
      samples_sent++;
   endtask

   task automatic check_output(input rsp_word_type got);
      rsp_word_type want;
      if (expected_outputs.size() == 0) begin
         report_mismatch("unexpected result word, control_output", got.control_output, 0);
         return;
      end
      want = expected_outputs.pop_front();
      results_checked++;
      if (got.saturated) clipped_results++;
      if (got.control_output !== want.control_output)
         report_mismatch("control_output", got.control_output, want.control_output);
      if (got.saturated !== want.saturated)
         report_mismatch("saturated", got.saturated, want.saturated);
   endtask

   // random idle about 8 percent of the time, none inside the quiet window
   function automatic bit take_break();
      if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO) return 1'b0;
      return $urandom_range(99) < 8;
   endfunction

   function automatic logic signed [DATA_WIDTH-1:0] pick_meas(input meas_kind_e kind);
      case (kind)
         MEAS_HIGH:      return MEAS_MAX;
         MEAS_LOW:       return MEAS_MIN;
         MEAS_NEAR_ZERO: return DATA_WIDTH'(int'($urandom_range(0, 4095)) - 2048);
         MEAS_NONE:      return MEAS_ZERO;
         default:        return DATA_WIDTH'($urandom);
      endcase
   endfunction

   task automatic push_random_word(inout stim_entry_t item, inout int made);
      item.drain = (made % DRAIN_EVERY) == DRAIN_EVERY / 2;
      stim_q.push_back(item);
      made++;
   endtask

   // held measurement runs to drive the state toward clipping, fresh random runs, and clears
   task automatic build_random_part();
      int                           made;
      int                           mode;
      int                           run_len;
      logic signed [DATA_WIDTH-1:0] held [MEAS_COUNT];
      stim_entry_t                  item;
      made       = 0;
      item.typed = 1'b0;
      item.want  = '0;
      while (made < RANDOM_WORDS) begin
         mode = $urandom_range(99);
         if (mode < 10) begin
            item.word          = '0;
            item.word.req_type = REQ_CLEAR;
            item.word.pitch_rate = DATA_WIDTH'($urandom);
            push_random_word(item, made);
         end else begin
            run_len = (mode < 65) ? $urandom_range(10, 80) : $urandom_range(3, 30);
            for (int k = 0; k < MEAS_COUNT; k++)
               held[k] = pick_meas(meas_kind_e'($urandom_range(MEAS_NONE)));
            for (int n = 0; n < run_len && made < RANDOM_WORDS; n++) begin
               if (mode >= 65) begin
                  for (int k = 0; k < MEAS_COUNT; k++)
                     held[k] = pick_meas(meas_kind_e'($urandom_range(MEAS_NONE)));
               end
               item.word.req_type       = REQ_SAMPLE;
               item.word.pitch_rate     = held[0];
               item.word.vertical_accel = held[1];
               item.word.extra_accel    = held[2];
               push_random_word(item, made);
            end
         end
      end
   endtask

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end
   end

   // both channels: result check and stall, request acceptance and next word
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_output(rsp_data);
         rsp_stall <= take_break();
         if (req_valid && !req_stall) begin
            predict_word(driven_word);
            words_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (stim_q.size() != 0 && !(stim_q[0].drain && expected_outputs.size() != 0)
                && !take_break()) begin
               driven_word = stim_q.pop_front();
               req_valid <= 1'b1;
               req_data  <= driven_word.word;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      stim_entry_t item;
      foreach (ctl_state[i]) ctl_state[i] = 0;
      // directed table first, then the random part
      foreach (directed_rows[r]) begin
         item.word.req_type       = directed_rows[r].op;
         item.word.pitch_rate     = directed_rows[r].y0;
         item.word.vertical_accel = directed_rows[r].y1;
         item.word.extra_accel    = directed_rows[r].y2;
         item.typed               = directed_rows[r].typed;
         item.want.control_output = directed_rows[r].u;
         item.want.saturated      = directed_rows[r].sat;
         item.drain               = 1'b0;
         stim_q.push_back(item);
      end
      build_random_part();
      words_total = stim_q.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (words_accepted != words_total) @(posedge clock);
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("sent %0d sample words and %0d clear words, %0d directed", samples_sent,
               clears_sent, DIRECTED_ROWS);
      $display("checked %0d result words, %0d of them clipped, %0d mismatches", results_checked,
               clipped_results, mismatch_count);
      if (mismatch_count == 0 && expected_outputs.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
